FILE: rtl/core/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg: shared types and constants of the GCD fraction reducer.
// Holds the field width, the default working width and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gfr_pkg;

	// Width of every numeric field on the ports.
	localparam int FIELD_W = 32;

	// Default working width of the operands.
	localparam int DEF_WIDTH = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;           // take a new operand pair
		logic gcd_step;       // one binary GCD step, or latch the divisor
		logic div_start;      // start the shared divider
		logic div_second;     // divider works on the second operand
		logic capture_first;  // store the quotient of the first operand
		logic capture_second; // store the quotient of the second operand
		logic write_out;      // move the finished result to the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic both_zero; // both operands are zero
		logic gcd_done;  // the divisor is known in this cycle
		logic div_done;  // the divider has a quotient
		logic out_free;  // the output register can take a result
	} stat_t;

endpackage

FILE: rtl/core/gfr_divider.sv
// ----------------------------------------------------------------------------
// gfr_divider: restoring bit-serial unsigned divider.
// Produces one quotient bit per cycle and pulses done when the quotient is
// ready. The divisor must stay stable while the division runs.
// ----------------------------------------------------------------------------
module gfr_divider #(
	parameter int W = gfr_pkg::DEF_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	import gfr_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic         busy_q;
	logic         done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         fits;
	logic         last;

	// Trial subtraction of the divisor from the partial remainder.
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};
	assign last  = busy_q && (cnt_q == CW'(1));

	// Control: busy flag and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last;
			if (start) begin
				busy_q <= 1'b1;
			end else if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			cnt_q <= CW'(W);
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/gfr_datapath.sv
// ----------------------------------------------------------------------------
// gfr_datapath: operand registers, binary GCD step logic and output register.
// Finds the divisor one step per cycle, then divides both operands by it on
// the shared divider and holds the result until the transaction completes.
// ----------------------------------------------------------------------------
module gfr_datapath #(
	parameter int WIDTH = gfr_pkg::DEF_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gfr_pkg::cmd_t               cmd,
	output gfr_pkg::stat_t              stat,
	input  logic [gfr_pkg::FIELD_W-1:0] first_value,
	input  logic [gfr_pkg::FIELD_W-1:0] second_value,
	input  logic                        result_stall,
	output logic                        result_valid,
	output logic [gfr_pkg::FIELD_W-1:0] divisor,
	output logic [gfr_pkg::FIELD_W-1:0] reduced_first,
	output logic [gfr_pkg::FIELD_W-1:0] reduced_second,
	output logic                        invalid
);
	import gfr_pkg::*;

	// Working width: the operands are taken modulo 2^VW.
	localparam int VW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
	localparam int KW = $clog2(VW);

	logic [VW-1:0] a_q;
	logic [VW-1:0] b_q;
	logic [VW-1:0] orig_a_q;
	logic [VW-1:0] orig_b_q;
	logic [KW-1:0] k_q;
	logic [VW-1:0] g_q;
	logic          inv_q;
	logic [VW-1:0] red_first_q;
	logic [VW-1:0] red_second_q;
	logic [VW-1:0] g_next;
	logic          gcd_done;
	logic          div_done;
	logic [VW-1:0] quotient;
	logic [VW-1:0] dividend;

	logic                result_valid_q;
	logic [FIELD_W-1:0]  divisor_q;
	logic [FIELD_W-1:0]  reduced_first_q;
	logic [FIELD_W-1:0]  reduced_second_q;
	logic                invalid_q;

	// The divisor is found when an operand is zero or both are equal.
	assign gcd_done = (a_q == '0) || (b_q == '0) || (a_q == b_q);
	assign g_next   = ((a_q == '0) ? b_q : a_q) << k_q;

	// Shared divider for both reduced values.
	assign dividend = cmd.div_second ? orig_b_q : orig_a_q;

	gfr_divider #(
		.W(VW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Operand registers and binary GCD steps.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q          <= first_value[VW-1:0];
			b_q          <= second_value[VW-1:0];
			orig_a_q     <= first_value[VW-1:0];
			orig_b_q     <= second_value[VW-1:0];
			k_q          <= '0;
			g_q          <= '0;
			inv_q        <= (first_value[VW-1:0] == '0) && (second_value[VW-1:0] == '0);
			red_first_q  <= '0;
			red_second_q <= '0;
		end else if (cmd.gcd_step) begin
			if (gcd_done) begin
				g_q <= g_next;
			end else if (!a_q[0] && !b_q[0]) begin
				// A common factor of two moves into the shift count.
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end else begin
			if (cmd.capture_first) begin
				red_first_q <= quotient;
			end
			if (cmd.capture_second) begin
				red_second_q <= quotient;
			end
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			divisor_q        <= FIELD_W'(g_q);
			reduced_first_q  <= FIELD_W'(red_first_q);
			reduced_second_q <= FIELD_W'(red_second_q);
			invalid_q        <= inv_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.both_zero = inv_q;
		stat.gcd_done  = gcd_done;
		stat.div_done  = div_done;
		stat.out_free  = !result_valid_q || !result_stall;
	end

	assign result_valid   = result_valid_q;
	assign divisor        = divisor_q;
	assign reduced_first  = reduced_first_q;
	assign reduced_second = reduced_second_q;
	assign invalid        = invalid_q;

endmodule

FILE: rtl/core/gfr_controller.sv
// ----------------------------------------------------------------------------
// gfr_controller: sequencer of the GCD fraction reducer.
// Steps one operand pair through the GCD search, two divisions (skipped when
// both operands are zero) and the write into the output register.
// ----------------------------------------------------------------------------
module gfr_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           operand_valid,
	output logic           operand_stall,
	input  gfr_pkg::stat_t stat,
	output gfr_pkg::cmd_t  cmd
);
	import gfr_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_GCD     = 3'd1;
	localparam logic [2:0] S_D1_GO   = 3'd2;
	localparam logic [2:0] S_D1_WAIT = 3'd3;
	localparam logic [2:0] S_D2_GO   = 3'd4;
	localparam logic [2:0] S_D2_WAIT = 3'd5;
	localparam logic [2:0] S_WRITE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (operand_valid) begin
					cmd.load = 1'b1;
					state_d  = S_GCD;
				end
			end
			S_GCD: begin
				cmd.gcd_step = 1'b1;
				if (stat.both_zero) begin
					state_d = S_WRITE;
				end else if (stat.gcd_done) begin
					state_d = S_D1_GO;
				end
			end
			S_D1_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_D1_WAIT;
			end
			S_D1_WAIT: begin
				if (stat.div_done) begin
					cmd.capture_first = 1'b1;
					state_d           = S_D2_GO;
				end
			end
			S_D2_GO: begin
				cmd.div_start  = 1'b1;
				cmd.div_second = 1'b1;
				state_d        = S_D2_WAIT;
			end
			S_D2_WAIT: begin
				cmd.div_second = 1'b1;
				if (stat.div_done) begin
					cmd.capture_second = 1'b1;
					state_d            = S_WRITE;
				end
			end
			S_WRITE: begin
				if (stat.out_free) begin
					cmd.write_out = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign operand_stall = (state_q != S_IDLE);

endmodule

FILE: rtl/core/gcd_fraction_reducer_unit.sv
// Sequence: a load, the binary GCD steps, two divisions on the shared
// bit-serial divider, and the write into the output register.
// One item is in work at a time, and the next is taken once the result is
// written. Both zero operands skip the divisions. Reset clears the sequencer,
// the divider's busy and done flags and the output valid flag; no other
// state is kept between items.
// ----------------------------------------------------------------------------
// gcd_fraction_reducer_unit: reduces a fraction to lowest terms.
// Finds the greatest common divisor of two unsigned operands and returns it
// with both operands divided by it, or an invalid flag for two zeros.
// ----------------------------------------------------------------------------
module gcd_fraction_reducer_unit #(
	parameter int WIDTH = gfr_pkg::DEF_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        operand_valid,
	output logic                        operand_stall,
	input  logic [gfr_pkg::FIELD_W-1:0] first_value,
	input  logic [gfr_pkg::FIELD_W-1:0] second_value,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [gfr_pkg::FIELD_W-1:0] divisor,
	output logic [gfr_pkg::FIELD_W-1:0] reduced_first,
	output logic [gfr_pkg::FIELD_W-1:0] reduced_second,
	output logic                        invalid
);
	import gfr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	gfr_controller u_controller (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.stat          (stat),
		.cmd           (cmd)
	);

	// Arithmetic and output register.
	gfr_datapath #(
		.WIDTH(WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.first_value    (first_value),
		.second_value   (second_value),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.divisor        (divisor),
		.reduced_first  (reduced_first),
		.reduced_second (reduced_second),
		.invalid        (invalid)
	);

`ifndef NO_ASSERTIONS
	// After a transaction on the operand side the block is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(operand_valid && !operand_stall) |=> operand_stall)
		else $error("operand side not busy after accept");

	// The controller issues at most one datapath action per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.gcd_step, cmd.div_start, cmd.capture_first,
			cmd.capture_second, cmd.write_out}))
		else $error("conflicting datapath commands");

	// A result is never written over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (!result_valid || !result_stall))
		else $error("pending result overwritten");

	// A valid result that is not flagged invalid always has a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !invalid) |-> (divisor != '0))
		else $error("zero divisor on a valid result");
`endif

endmodule

FILE: test/gcd_fraction_reducer_unit_tb.sv
// ----------------------------------------------------------------------------
// gcd_fraction_reducer_unit_tb: self-checking bench for the fraction reducer.
// Walks a short table of corner operand pairs, then about 1400 random pairs.
// The random pairs favor shared factors, equal and zero operands and
// Fibonacci pairs, which take the longest. Every result is compared with a
// typed table entry or a local GCD model. Both sides insert random idle
// bursts, and the last stretch of the run has none.
// ----------------------------------------------------------------------------
module gcd_fraction_reducer_unit_tb;

	localparam int FW           = gfr_pkg::FIELD_W;
	localparam int VALUE_W      = gfr_pkg::DEF_WIDTH;
	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CALM_ITEMS   = 200;
	localparam int DRAIN_CYCLES = 160;
	localparam int LIMIT_CYCLES = 1200000;
	localparam int REPORT_MAX   = 10;
	localparam int TABLE_ROWS   = 24;

	// Operands are reduced modulo 2^WIDTH before the GCD is taken.
	localparam logic [FW-1:0] VALUE_MASK = (VALUE_W >= FW) ? {FW{1'b1}} :
		((FW'(1) << VALUE_W) - FW'(1));

	// One result transaction.
	typedef struct packed {
		logic [FW-1:0] divisor;
		logic [FW-1:0] reduced_first;
		logic [FW-1:0] reduced_second;
		logic          invalid;
	} fraction_t;

	// One row of the directed table; the result is typed in where it is obvious.
	typedef struct packed {
		logic [FW-1:0] numer;
		logic [FW-1:0] denom;
		bit            typed;
		fraction_t     want;
	} operand_row_t;

	logic          clk;
	logic          arst_n;
	logic          operand_valid;
	logic          operand_stall;
	logic [FW-1:0] first_value;
	logic [FW-1:0] second_value;
	logic          result_valid;
	logic          result_stall;
	logic [FW-1:0] divisor;
	logic [FW-1:0] reduced_first;
	logic [FW-1:0] reduced_second;
	logic          invalid;

	fraction_t pending_fractions [$];
	fraction_t seen_frac;
	fraction_t due_frac;
	bit        idling_on;
	int        mismatch_count;
	int        results_checked;
	int        invalid_seen;
	int        unit_divisor_seen;
	int        directed_sent;
	int        random_sent;

	// Corner pairs: zeros, all ones, equal, coprime and slow Euclid chains.
	operand_row_t directed_table [0:TABLE_ROWS-1] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
		'{32'h0000_0000, 32'h0000_0005, 1'b1, '{32'h5, 32'h0, 32'h1, 1'b0}},
		'{32'h0000_0007, 32'h0000_0000, 1'b1, '{32'h7, 32'h1, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h1, 32'h0, 32'h1, 1'b0}},
		'{32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h1, 32'h1, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0}},
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h1, 32'h0, 1'b0}},
		'{32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h8000_0000, 32'h1, 32'h0, 1'b0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'h1, 32'h1, 1'b0}},
		'{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h8000_0000, 32'h1, 32'h1, 1'b0}},
		'{32'd12345, 32'd12345, 1'b1, '{32'd12345, 32'h1, 32'h1, 1'b0}},
		'{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h1, 32'h1, 32'h1, 1'b0}},
		'{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h1, 32'hFFFF_FFFF, 32'h1, 1'b0}},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h1, 32'h1, 32'hFFFF_FFFF, 1'b0}},
		'{32'd17, 32'd19, 1'b1, '{32'h1, 32'd17, 32'd19, 1'b0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, '{32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0}},
		'{32'd12, 32'd18, 1'b0, '0},
		'{32'h8000_0000, 32'h4000_0000, 1'b0, '0},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFC, 1'b0, '0},
		'{32'd2971215073, 32'd1836311903, 1'b0, '0},
		'{32'd1836311903, 32'd2971215073, 1'b0, '0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
		'{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
		'{32'h0000_0003, 32'hC000_0000, 1'b0, '0}
	};

	gcd_fraction_reducer_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.operand_valid  (operand_valid),
		.operand_stall  (operand_stall),
		.first_value    (first_value),
		.second_value   (second_value),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.divisor        (divisor),
		.reduced_first  (reduced_first),
		.reduced_second (reduced_second),
		.invalid        (invalid)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Euclid's remainder method, then both operands divided by the divisor.
	function automatic fraction_t reduce_fraction(input logic [FW-1:0] numer,
			input logic [FW-1:0] denom);
		logic [FW-1:0] a;
		logic [FW-1:0] b;
		logic [FW-1:0] x;
		logic [FW-1:0] y;
		logic [FW-1:0] rem;
		fraction_t     frac;
		a = numer & VALUE_MASK;
		b = denom & VALUE_MASK;
		frac = '0;
		if (a == '0 && b == '0) begin
			frac.invalid = 1'b1;
			return frac;
		end
		x = a;
		y = b;
		while (y != '0) begin
			rem = x % y;
			x = y;
			y = rem;
		end
		frac.divisor = x;
		frac.reduced_first = a / x;
		frac.reduced_second = b / x;
		return frac;
	endfunction

	// Random value of the given bit length.
	function automatic logic [FW-1:0] rand_bits(input int nbits);
		if (nbits <= 0)
			return '0;
		return FW'($urandom) >> (FW - nbits);
	endfunction

	// Random operand pair, weighted toward the interesting cases.
	task automatic pick_operands(output logic [FW-1:0] a, output logic [FW-1:0] b);
		int            kind;
		int            gbits;
		int            steps;
		logic [FW-1:0] factor;
		logic [FW-1:0] fa;
		logic [FW-1:0] fb;
		logic [FW-1:0] fnext;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			a = $urandom;
			b = $urandom;
		end else if (kind < 60) begin
			// Shared factor, sized so that neither product overflows.
			gbits = $urandom_range(1, 24);
			factor = rand_bits(gbits) | FW'(1);
			a = factor * rand_bits($urandom_range(0, FW - gbits));
			b = factor * rand_bits($urandom_range(0, FW - gbits));
		end else if (kind < 70) begin
			a = rand_bits($urandom_range(1, FW));
			b = a;
		end else if (kind < 78) begin
			a = rand_bits($urandom_range(1, FW));
			b = '0;
			if ($urandom_range(0, 1) == 1) begin
				b = a;
				a = '0;
			end
		end else if (kind < 81) begin
			a = '0;
			b = '0;
		end else if (kind < 90) begin
			a = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
		end else if (kind < 95) begin
			// Consecutive Fibonacci numbers give the longest remainder chains.
			steps = $urandom_range(1, 45);
			fa = FW'(1);
			fb = FW'(1);
			repeat (steps) begin
				fnext = fa + fb;
				fa = fb;
				fb = fnext;
			end
			a = fb;
			b = fa;
			if ($urandom_range(0, 1) == 1) begin
				a = fa;
				b = fb;
			end
		end else begin
			a = FW'(1) << $urandom_range(0, FW - 1);
			b = $urandom;
		end
	endtask

	// Offer one operand transaction and record what it must produce.
	task automatic send_operands(input logic [FW-1:0] a, input logic [FW-1:0] b,
			input bit typed, input fraction_t want);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			operand_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		operand_valid = 1'b1;
		first_value = a;
		second_value = b;
		do
			@(posedge clk);
		while (operand_stall);
		if (typed)
			pending_fractions.push_back(want);
		else
			pending_fractions.push_back(reduce_fraction(a, b));
		@(negedge clk);
	endtask

	// Count a failure and show the first few.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("[%0t] %s", $realtime, what);
			$display("    expected div=%h first=%h second=%h inv=%b", due_frac.divisor,
				due_frac.reduced_first, due_frac.reduced_second, due_frac.invalid);
			$display("    actual   div=%h first=%h second=%h inv=%b", seen_frac.divisor,
				seen_frac.reduced_first, seen_frac.reduced_second, seen_frac.invalid);
		end
	endtask

	// Result side: random stall bursts while idling is on.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 6);
			if (stall_left != 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	// Compare each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			seen_frac = '{divisor, reduced_first, reduced_second, invalid};
			if (pending_fractions.size() == 0) begin
				due_frac = 'x;
				report_mismatch("result transaction with nothing expected");
			end else begin
				due_frac = pending_fractions.pop_front();
				results_checked++;
				if (seen_frac.invalid)
					invalid_seen++;
				if (seen_frac.divisor == FW'(1))
					unit_divisor_seen++;
				if (seen_frac.divisor !== due_frac.divisor ||
						seen_frac.reduced_first !== due_frac.reduced_first ||
						seen_frac.reduced_second !== due_frac.reduced_second ||
						seen_frac.invalid !== due_frac.invalid)
					report_mismatch($sformatf("result %0d differs", results_checked));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int            idx;
		logic [FW-1:0] a;
		logic [FW-1:0] b;
		arst_n = 1'b0;
		operand_valid = 1'b0;
		first_value = '0;
		second_value = '0;
		idling_on = 1'b1;
		mismatch_count = 0;
		results_checked = 0;
		invalid_seen = 0;
		unit_divisor_seen = 0;
		directed_sent = 0;
		random_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (idx = 0; idx < TABLE_ROWS; idx++) begin
			send_operands(directed_table[idx].numer, directed_table[idx].denom,
				directed_table[idx].typed, directed_table[idx].want);
			directed_sent++;
		end

		// Random pairs; idling switches off now and then and for the final stretch.
		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			idling_on = (idx < RANDOM_ITEMS - CALM_ITEMS) && ((idx / 120) % 4 != 3);
			pick_operands(a, b);
			send_operands(a, b, 1'b0, '0);
			random_sent++;
		end
		operand_valid = 1'b0;

		while (pending_fractions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d table pairs and %0d random pairs; %0d results checked.",
			directed_sent, random_sent, results_checked);
		$display("Of these, %0d had both operands zero and %0d had a divisor of one.",
			invalid_seen, unit_divisor_seen);
		if (mismatch_count == 0) begin
			$display("** gcd_fraction_reducer_unit: PASSED **");
		end else begin
			$display("%0d mismatches in total.", mismatch_count);
			$display("** gcd_fraction_reducer_unit: FAILED **");
		end
		$finish;
	end

	// Hang guard.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d results still expected.", pending_fractions.size());
		$display("** gcd_fraction_reducer_unit: FAILED **");
		$finish;
	end

endmodule
